@@ src/sftrm_pkg.sv @@
`default_nettype none
// ============================================================================
// sftrm_pkg
// Shared types and constants of the SYN flood tracker: TCP flag codes,
// configuration register indexes and the sequencer state encoding.
// ============================================================================
package sftrm_pkg;

    // TCP flag byte codes of interest
    localparam logic [7:0] FLAGS_PURE_ACK = 8'h10;
    localparam logic [7:0] FLAGS_SYN_ACK  = 8'h12;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_SRC_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_DST_ADDRESS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_SRC_PORT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_DST_PORT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOD_THRESHOLD  = 3'd5;

    // Wildcard mask bit positions
    localparam int WC_SRC_ADDRESS = 0;
    localparam int WC_DST_ADDRESS = 1;
    localparam int WC_SRC_PORT    = 2;
    localparam int WC_DST_PORT    = 3;

    // Register reset values
    localparam logic [3:0] WILDCARD_MASK_RESET   = 4'hF;
    localparam logic [6:0] FLOOD_THRESHOLD_RESET = 7'd10;

    // Reported occupancy saturates at this value
    localparam int OPEN_COUNT_MAX = 127;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_INS_RD = 6'b001000,
        ST_INS_WR = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

endpackage
`default_nettype wire

@@ src/syn_flood_tracker_with_rule_match_core.sv @@
`default_nettype none
// ============================================================================
// syn_flood_tracker_with_rule_match_core
// Tracks half-open TCP handshakes in a table of expected ACK numbers and
// raises an alert when their count exceeds a threshold on a rule match.
// ============================================================================
// One packet summary is taken per input beat and yields one result beat.
// The table lives in a single synchronous memory (one write and one read
// port, read data registered). After reset no input beat is accepted
// while a clearing pass writes zero to every entry; configuration writes
// are taken at all times. A pure ACK walks the whole table through the
// memory read port. A SYN-ACK does one read-modify-write at the insert
// pointer; any other packet goes straight to the finish state. The
// occupancy count is kept in a register and updated on every scan clear
// and insert write. The result sits in an output register, so the next
// beat is taken while a result waits; it stalls only in the finish state
// when the previous result has not been taken yet.
// ============================================================================
module syn_flood_tracker_with_rule_match_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write port
    input  wire logic        cfg_write_enable,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    // packet summary channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        is_tcp,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [31:0] seq_number,
    input  wire logic [31:0] ack_num,
    input  wire logic [31:0] src_address,
    input  wire logic [31:0] dst_address,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,

    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             flood_alert,
    output logic             rule_hit,
    output logic [6:0]       open_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW:0]   SCAN_END  = (AW+1)'(TABLE_DEPTH);
    localparam logic [AW:0]   SCAN_LAST = (AW+1)'(TABLE_DEPTH - 1);
    localparam logic [AW-1:0] PTR_LAST  = AW'(TABLE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] rule_src_address_reg;
    logic [31:0] rule_dst_address_reg;
    logic [15:0] rule_src_port_reg;
    logic [15:0] rule_dst_port_reg;
    logic [3:0]  wildcard_mask_reg;
    logic [6:0]  flood_threshold_reg;

    // decode and store configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_src_address_reg <= '0;
            rule_dst_address_reg <= '0;
            rule_src_port_reg    <= '0;
            rule_dst_port_reg    <= '0;
            wildcard_mask_reg    <= sftrm_pkg::WILDCARD_MASK_RESET;
            flood_threshold_reg  <= sftrm_pkg::FLOOD_THRESHOLD_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                sftrm_pkg::REG_RULE_SRC_ADDRESS: rule_src_address_reg <= cfg_data;
                sftrm_pkg::REG_RULE_DST_ADDRESS: rule_dst_address_reg <= cfg_data;
                sftrm_pkg::REG_RULE_SRC_PORT:    rule_src_port_reg    <= cfg_data[15:0];
                sftrm_pkg::REG_RULE_DST_PORT:    rule_dst_port_reg    <= cfg_data[15:0];
                sftrm_pkg::REG_WILDCARD_MASK:    wildcard_mask_reg    <= cfg_data[3:0];
                sftrm_pkg::REG_FLOOD_THRESHOLD:  flood_threshold_reg  <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Rule match on the incoming beat
    // ------------------------------------------------------------------
    logic hit_now;

    assign hit_now =
        (wildcard_mask_reg[sftrm_pkg::WC_SRC_ADDRESS] || src_address == rule_src_address_reg) &&
        (wildcard_mask_reg[sftrm_pkg::WC_DST_ADDRESS] || dst_address == rule_dst_address_reg) &&
        (wildcard_mask_reg[sftrm_pkg::WC_SRC_PORT]    || src_port    == rule_src_port_reg)    &&
        (wildcard_mask_reg[sftrm_pkg::WC_DST_PORT]    || dst_port    == rule_dst_port_reg);

    // ------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------
    logic [31:0]   table_mem [TABLE_DEPTH];
    logic [31:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    sftrm_pkg::state_t state_reg, state_next;
    logic [AW:0]   scan_cnt_reg, scan_cnt_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic [AW-1:0] ins_ptr_reg, ins_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic          tcp_reg, tcp_next;
    logic          hit_reg, hit_next;
    logic [31:0]   seq_reg, seq_next;
    logic [31:0]   ack_reg, ack_next;

    logic          out_valid_reg, out_valid_next;
    logic          alert_reg, alert_next;
    logic          rule_hit_reg, rule_hit_next;
    logic [6:0]    open_count_reg, open_count_next;

    logic [31:0]   ins_value;
    logic [6:0]    count_sat;

    assign ins_value = seq_reg + 32'd1;

    // saturate occupancy to the reported width
    always_comb
    begin
        if (int'(count_reg) > sftrm_pkg::OPEN_COUNT_MAX)
        begin
            count_sat = 7'(sftrm_pkg::OPEN_COUNT_MAX);
        end
        else
        begin
            count_sat = 7'(count_reg);
        end
    end

    // next-state and memory access logic
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = chk_addr_reg;
        ins_ptr_next    = ins_ptr_reg;
        count_next      = count_reg;
        tcp_next        = tcp_reg;
        hit_next        = hit_reg;
        seq_next        = seq_reg;
        ack_next        = ack_reg;
        out_valid_next  = out_valid_reg;
        alert_next      = alert_reg;
        rule_hit_next   = rule_hit_reg;
        open_count_next = open_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_addr_reg;
        mem_wdata       = '0;
        mem_raddr       = scan_cnt_reg[AW-1:0];

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sftrm_pkg::ST_CLEAR:
            begin
                // sweep zero through the table
                mem_we    = 1'b1;
                mem_waddr = scan_cnt_reg[AW-1:0];
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    scan_cnt_next = '0;
                    state_next    = sftrm_pkg::ST_IDLE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + (AW+1)'(1);
                end
            end

            sftrm_pkg::ST_IDLE:
            begin
                // hold the beat and pick the table operation
                if (in_valid)
                begin
                    tcp_next      = is_tcp;
                    hit_next      = hit_now;
                    seq_next      = seq_number;
                    ack_next      = ack_num;
                    scan_cnt_next = '0;
                    if (is_tcp && tcp_flags == sftrm_pkg::FLAGS_PURE_ACK)
                    begin
                        state_next = sftrm_pkg::ST_SCAN;
                    end
                    else if (is_tcp && tcp_flags == sftrm_pkg::FLAGS_SYN_ACK)
                    begin
                        state_next = sftrm_pkg::ST_INS_RD;
                    end
                    else
                    begin
                        state_next = sftrm_pkg::ST_FINISH;
                    end
                end
            end

            sftrm_pkg::ST_SCAN:
            begin
                // issue one read per cycle, check the entry read last cycle
                if (scan_cnt_reg != SCAN_END)
                begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_cnt_reg[AW-1:0];
                    scan_cnt_next  = scan_cnt_reg + (AW+1)'(1);
                end
                if (chk_valid_reg && rd_data_reg == ack_reg && ack_reg != 32'd0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = chk_addr_reg;
                    mem_wdata  = '0;
                    count_next = count_reg - CW'(1);
                end
                if (scan_cnt_reg == SCAN_END && !chk_valid_reg)
                begin
                    state_next = sftrm_pkg::ST_FINISH;
                end
            end

            sftrm_pkg::ST_INS_RD:
            begin
                mem_raddr  = ins_ptr_reg;
                state_next = sftrm_pkg::ST_INS_WR;
            end

            sftrm_pkg::ST_INS_WR:
            begin
                // overwrite the slot and adjust occupancy
                mem_we     = 1'b1;
                mem_waddr  = ins_ptr_reg;
                mem_wdata  = ins_value;
                count_next = count_reg + CW'(ins_value != 32'd0)
                                       - CW'(rd_data_reg != 32'd0);
                if (ins_ptr_reg == PTR_LAST)
                begin
                    ins_ptr_next = '0;
                end
                else
                begin
                    ins_ptr_next = ins_ptr_reg + AW'(1);
                end
                state_next = sftrm_pkg::ST_FINISH;
            end

            sftrm_pkg::ST_FINISH:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    rule_hit_next   = hit_reg;
                    open_count_next = count_sat;
                    alert_next      = tcp_reg && hit_reg && (count_sat > flood_threshold_reg);
                    state_next      = sftrm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sftrm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sftrm_pkg::ST_CLEAR;
            scan_cnt_reg  <= '0;
            chk_valid_reg <= 1'b0;
            ins_ptr_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            chk_valid_reg <= chk_valid_next;
            ins_ptr_reg   <= ins_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        tcp_reg        <= tcp_next;
        hit_reg        <= hit_next;
        seq_reg        <= seq_next;
        ack_reg        <= ack_next;
        alert_reg      <= alert_next;
        rule_hit_reg   <= rule_hit_next;
        open_count_reg <= open_count_next;
    end

    assign in_ready    = (state_reg == sftrm_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign flood_alert = alert_reg;
    assign rule_hit    = rule_hit_reg;
    assign open_count  = open_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= TABLE_DEPTH)
        else $error("occupancy count exceeds table depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ins_ptr_reg) < TABLE_DEPTH)
        else $error("insert pointer out of range");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sftrm_pkg::ST_IDLE |-> !mem_we)
        else $error("table write while idle");

    a_scan_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sftrm_pkg::ST_SCAN && mem_we && scan_cnt_reg != SCAN_END)
        |-> mem_waddr != mem_raddr)
        else $error("scan write collides with scan read");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while one is in work");

    a_alert_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && flood_alert) |-> rule_hit)
        else $error("alert without rule hit");

endmodule
`default_nettype wire

@@ verif/tb_syn_flood_tracker_with_rule_match_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_syn_flood_tracker_with_rule_match_core
// Self-checking bench for the SYN flood tracker. A directed table covers the
// reset state, field extremes, sequence wrap, duplicate entries and the
// non-TCP and other-flag paths; random phases then drive SYN-ACK / pure ACK
// traffic under several rule settings, with random idling on both channels
// and one long result hold-off. Every result beat is checked against an
// in-bench model of the half-open table and rule match, or a fixed verdict.
// ============================================================================
module tb_syn_flood_tracker_with_rule_match_core;

    localparam int          DEPTH       = 64;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 100;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [7:0]  FLAGS_ALL   = 8'hFF;
    localparam logic [7:0]  FLAGS_NONE  = 8'h00;
    // indexes the block does not decode
    localparam logic [2:0]  REG_SPARE_6 = 3'd6;
    localparam logic [2:0]  REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic        is_tcp;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
    } pkt_t;

    typedef struct packed {
        logic       alert;
        logic       hit;
        logic [6:0] count;
    } verdict_t;

    typedef struct packed {
        pkt_t     pkt;
        logic     typed;
        verdict_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        is_tcp = 1'b0;
    logic [7:0]  tcp_flags = '0;
    logic [31:0] seq_number = '0;
    logic [31:0] ack_num = '0;
    logic [31:0] src_address = '0;
    logic [31:0] dst_address = '0;
    logic [15:0] src_port = '0;
    logic [15:0] dst_port = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        flood_alert;
    logic        rule_hit;
    logic [6:0]  open_count;

    // model state: half-open table, insert pointer, rule registers
    logic [31:0] half_open [DEPTH];
    logic [5:0]  ins_ptr;
    logic [31:0] rule_sa;
    logic [31:0] rule_da;
    logic [15:0] rule_sp;
    logic [15:0] rule_dp;
    logic [3:0]  wc_mask;
    logic [6:0]  thresh;

    verdict_t verdict_q [$];
    row_t     directed_rows [$];

    logic steady = 1'b0;
    logic stall_rx = 1'b0;
    int   phase_no = -1;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   alerts_seen = 0;
    int   hits_seen = 0;
    int   peak_open = 0;
    int   syn_acks = 0;
    int   pure_acks = 0;

    syn_flood_tracker_with_rule_match_core #(.TABLE_DEPTH(DEPTH)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .is_tcp           (is_tcp),
        .tcp_flags        (tcp_flags),
        .seq_number       (seq_number),
        .ack_num          (ack_num),
        .src_address      (src_address),
        .dst_address      (dst_address),
        .src_port         (src_port),
        .dst_port         (dst_port),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .flood_alert      (flood_alert),
        .rule_hit         (rule_hit),
        .open_count       (open_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Update the half-open table for one packet and return its verdict
    function automatic verdict_t track_packet(input pkt_t p);
        verdict_t v;
        int       n;
        logic     hit;
        n = 0;
        if (p.is_tcp)
        begin
            if (p.flags == sftrm_pkg::FLAGS_PURE_ACK)
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (half_open[i] == p.ack)
                        half_open[i] = '0;
            end
            if (p.flags == sftrm_pkg::FLAGS_SYN_ACK)
            begin
                half_open[ins_ptr] = p.seq + 32'd1;
                ins_ptr = ins_ptr + 6'd1;
            end
        end
        for (int i = 0; i < DEPTH; i++)
            if (half_open[i] != '0)
                n++;
        if (n > sftrm_pkg::OPEN_COUNT_MAX)
            n = sftrm_pkg::OPEN_COUNT_MAX;
        hit = (wc_mask[sftrm_pkg::WC_SRC_ADDRESS] || p.saddr == rule_sa) &&
              (wc_mask[sftrm_pkg::WC_DST_ADDRESS] || p.daddr == rule_da) &&
              (wc_mask[sftrm_pkg::WC_SRC_PORT]    || p.sport == rule_sp) &&
              (wc_mask[sftrm_pkg::WC_DST_PORT]    || p.dport == rule_dp);
        v.count = n[6:0];
        v.hit   = hit;
        v.alert = p.is_tcp && hit && (n > int'(thresh));
        return v;
    endfunction

    function automatic pkt_t mk(input logic tcp, input logic [7:0] fl,
                                input logic [31:0] sq, input logic [31:0] ak,
                                input logic [31:0] sa, input logic [31:0] da,
                                input logic [15:0] sp, input logic [15:0] dp);
        pkt_t p;
        p = '{tcp, fl, sq, ak, sa, da, sp, dp};
        return p;
    endfunction

    task automatic add_row(input pkt_t p, input logic typed, input verdict_t want);
        directed_rows.push_back('{p, typed, want});
    endtask

    // Pick a field value that mostly matches the rule, sometimes an extreme
    function automatic logic [31:0] aim(input logic [31:0] rule_val);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return rule_val;
        else if (r < 80)
            return '1;
        else if (r < 85)
            return '0;
        return $urandom;
    endfunction

    // Write one register and mirror it in the model
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(posedge clk);
        case (idx)
            sftrm_pkg::REG_RULE_SRC_ADDRESS: rule_sa = val;
            sftrm_pkg::REG_RULE_DST_ADDRESS: rule_da = val;
            sftrm_pkg::REG_RULE_SRC_PORT:    rule_sp = val[15:0];
            sftrm_pkg::REG_RULE_DST_PORT:    rule_dp = val[15:0];
            sftrm_pkg::REG_WILDCARD_MASK:    wc_mask = val[3:0];
            sftrm_pkg::REG_FLOOD_THRESHOLD:  thresh  = val[6:0];
            default: ;
        endcase
    endtask

    task automatic load_rules(input logic [31:0] sa, input logic [31:0] da,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input logic [3:0] mask, input logic [6:0] thr);
        write_reg(sftrm_pkg::REG_RULE_SRC_ADDRESS, sa);
        write_reg(sftrm_pkg::REG_RULE_DST_ADDRESS, da);
        write_reg(sftrm_pkg::REG_RULE_SRC_PORT, {16'h0, sp});
        write_reg(sftrm_pkg::REG_RULE_DST_PORT, {16'h0, dp});
        write_reg(sftrm_pkg::REG_WILDCARD_MASK, {28'h0, mask});
        write_reg(sftrm_pkg::REG_FLOOD_THRESHOLD, {25'h0, thr});
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one packet beat, hold it until taken, then record its verdict
    task automatic send_packet(input pkt_t p, input logic typed, input verdict_t want);
        verdict_t v;
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        is_tcp      <= p.is_tcp;
        tcp_flags   <= p.flags;
        seq_number  <= p.seq;
        ack_num     <= p.ack;
        src_address <= p.saddr;
        dst_address <= p.daddr;
        src_port    <= p.sport;
        dst_port    <= p.dport;
        do
            @(posedge clk);
        while (!in_ready);
        v = track_packet(p);
        if (p.is_tcp && p.flags == sftrm_pkg::FLAGS_SYN_ACK)
            syn_acks++;
        if (p.is_tcp && p.flags == sftrm_pkg::FLAGS_PURE_ACK)
            pure_acks++;
        verdict_q.push_back(typed ? want : v);
    endtask

    // Random packets: mostly SYN-ACK / pure ACK, some other flags and non-TCP
    task automatic run_phase(input int n, input int syn_pct);
        pkt_t p;
        int   roll;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            p.is_tcp = 1'b1;
            p.flags  = 8'($urandom_range(0, 255));
            p.seq    = $urandom;
            p.ack    = $urandom;
            p.saddr  = aim(rule_sa);
            p.daddr  = aim(rule_da);
            p.sport  = 16'(aim({16'h0, rule_sp}));
            p.dport  = 16'(aim({16'h0, rule_dp}));
            if (roll < 8)
            begin
                p.is_tcp = 1'b0;
                if ($urandom_range(0, 1))
                    p.flags = $urandom_range(0, 1) ? sftrm_pkg::FLAGS_SYN_ACK
                                                   : sftrm_pkg::FLAGS_PURE_ACK;
            end
            else if (roll < 8 + syn_pct)
            begin
                p.flags = sftrm_pkg::FLAGS_SYN_ACK;
                if ($urandom_range(0, 15) == 0)
                    p.seq = '1;
                else if ($urandom_range(0, 7) == 0)
                    p.seq = $urandom_range(1, 8);
            end
            else if (roll < 90)
            begin
                p.flags = sftrm_pkg::FLAGS_PURE_ACK;
                if ($urandom_range(0, 99) < 70)
                    p.ack = half_open[6'($urandom_range(0, DEPTH - 1))];
                else if ($urandom_range(0, 3) == 0)
                    p.ack = $urandom_range(2, 9);
            end
            send_packet(p, 1'b0, '0);
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Result channel: random back-pressure, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_rx)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // Hold off the receiver long enough for the block to stall its input
    initial
    begin
        wait (phase_no == 2);
        repeat (20) @(posedge clk);
        stall_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_rx <= 1'b0;
    end

    // Compare each result beat with the oldest verdict
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (flood_alert)
                alerts_seen++;
            if (rule_hit)
                hits_seen++;
            if (int'(open_count) > peak_open)
                peak_open = int'(open_count);
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0d: alert=%0d hit=%0d count=%0d",
                             results_seen, flood_alert, rule_hit, open_count);
            end
            else
            begin
                v = verdict_q.pop_front();
                if (v.alert !== flood_alert || v.hit !== rule_hit || v.count !== open_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected alert=%0d hit=%0d count=%0d,",
                                  " got %0d %0d %0d"},
                                 results_seen, v.alert, v.hit, v.count,
                                 flood_alert, rule_hit, open_count);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("tb_syn_flood_tracker_with_rule_match_core: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            half_open[i] = '0;
        ins_ptr = '0;
        rule_sa = '0;
        rule_da = '0;
        rule_sp = '0;
        rule_dp = '0;
        wc_mask = sftrm_pkg::WILDCARD_MASK_RESET;
        thresh  = sftrm_pkg::FLOOD_THRESHOLD_RESET;

        // Directed table, default rule: everything wildcarded, threshold 10
        add_row(mk(1'b0, sftrm_pkg::FLAGS_SYN_ACK, '0, '0, '0, '0, '0, '0),
                1'b1, '{1'b0, 1'b1, 7'd0});
        add_row(mk(1'b1, sftrm_pkg::FLAGS_PURE_ACK, '1, '0, '1, '1, '1, '1),
                1'b1, '{1'b0, 1'b1, 7'd0});
        // seq+1 wraps to zero: slot stays empty
        add_row(mk(1'b1, sftrm_pkg::FLAGS_SYN_ACK, '1, '1, '0, '1, '0, '1),
                1'b1, '{1'b0, 1'b1, 7'd0});
        add_row(mk(1'b1, sftrm_pkg::FLAGS_SYN_ACK, '0, '0, '1, '0, '1, '0),
                1'b1, '{1'b0, 1'b1, 7'd1});
        for (int i = 0; i < 10; i++)
            add_row(mk(1'b1, sftrm_pkg::FLAGS_SYN_ACK, 32'd100 + i, $urandom, $urandom,
                       $urandom, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535))), 1'b0, '0);
        add_row(mk(1'b1, FLAGS_ALL, '1, 32'd101, '1, '1, '1, '1), 1'b0, '0);
        add_row(mk(1'b1, FLAGS_NONE, '0, 32'd101, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk(1'b0, sftrm_pkg::FLAGS_PURE_ACK, '0, 32'd101, '1, '1, '1, '1), 1'b0, '0);
        add_row(mk(1'b1, sftrm_pkg::FLAGS_PURE_ACK, '0, 32'd101, '0, '1, '0, '1), 1'b0, '0);
        add_row(mk(1'b1, sftrm_pkg::FLAGS_PURE_ACK, '0, 32'd1, '1, '0, '1, '0), 1'b0, '0);
        add_row(mk(1'b1, sftrm_pkg::FLAGS_SYN_ACK, 32'hFFFF_FFFE, '1, '1, '1, '1, '1),
                1'b0, '0);
        add_row(mk(1'b1, sftrm_pkg::FLAGS_PURE_ACK, '0, '1, '0, '0, '0, '0), 1'b0, '0);
        // duplicate entries are cleared together
        add_row(mk(1'b1, sftrm_pkg::FLAGS_SYN_ACK, 32'd500, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk(1'b1, sftrm_pkg::FLAGS_SYN_ACK, 32'd500, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk(1'b1, sftrm_pkg::FLAGS_PURE_ACK, '0, 32'd501, '0, '0, '0, '0), 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();

        // Exact rule, lowest threshold, no idling on either side
        phase_no = 0;
        steady   = 1'b1;
        load_rules($urandom, $urandom, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 4'h0, 7'd0);
        run_phase(90, 45);
        drain();
        steady = 1'b0;

        // Fill and wrap the table; a threshold of 64 never alerts
        phase_no = 1;
        load_rules('0, '0, '0, '0, 4'hF, 7'd64);
        run_phase(100, 75);
        drain();

        // All-ones rule, threshold just below a full table
        phase_no = 2;
        load_rules('1, '1, 16'hFFFF, 16'hFFFF, 4'h0, 7'd63);
        run_phase(80, 60);
        drain();

        // Random rule; undecoded indexes must be ignored
        phase_no = 3;
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        load_rules($urandom, $urandom, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)),
                   4'($urandom_range(0, 15)), 7'($urandom_range(0, 64)));
        run_phase(80, 45);
        drain();

        phase_no = 4;
        load_rules($urandom, $urandom, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)),
                   4'($urandom_range(0, 15)), 7'($urandom_range(0, 20)));
        run_phase(80, 50);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d SYN-ACK, %0d pure ACK, %0d rule hits, %0d alerts",
                 results_seen, syn_acks, pure_acks, hits_seen, alerts_seen);
        $display("peak occupancy %0d of %0d slots, %0d mismatches",
                 peak_open, DEPTH, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("tb_syn_flood_tracker_with_rule_match_core: PASS");
        else
            $display("tb_syn_flood_tracker_with_rule_match_core: FAIL");
        $finish;
    end

endmodule
